// File: rtl/gra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gra_pkg
// Shared types, codes and widths of the guillotine rectangle allocator.
// ----------------------------------------------------------------------------
package gra_pkg;

  localparam int CB     = 14;          // coordinate bits
  localparam int PB     = 8;           // padding bits
  localparam int AREA_W = 2 * (CB + 1); // product of two padded sizes

  typedef logic [CB-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } rect_t;

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_CHECK   = 2'd2;
  localparam logic [1:0] ACT_CLEAR   = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_NOSPACE = 3'd2;
  localparam logic [2:0] ST_FRAG    = 3'd3;
  localparam logic [2:0] ST_NOFIT   = 3'd4;
  localparam logic [2:0] ST_OVF     = 3'd5;

  localparam logic [1:0] CFG_AW  = 2'd0;
  localparam logic [1:0] CFG_AH  = 2'd1;
  localparam logic [1:0] CFG_PAD = 2'd2;

  localparam logic [4:0] OP_NONE         = 5'd0;
  localparam logic [4:0] OP_INIT         = 5'd1;
  localparam logic [4:0] OP_LOAD         = 5'd2;
  localparam logic [4:0] OP_PREP         = 5'd3;
  localparam logic [4:0] OP_AREA         = 5'd4;
  localparam logic [4:0] OP_CLEAR        = 5'd5;
  localparam logic [4:0] OP_SCAN_START   = 5'd6;
  localparam logic [4:0] OP_SCAN         = 5'd7;
  localparam logic [4:0] OP_REM_START_BI = 5'd8;
  localparam logic [4:0] OP_REM_RD       = 5'd9;
  localparam logic [4:0] OP_REM_WR       = 5'd10;
  localparam logic [4:0] OP_PUSH_R       = 5'd11;
  localparam logic [4:0] OP_PUSH_B       = 5'd12;
  localparam logic [4:0] OP_PUSH_REL     = 5'd13;
  localparam logic [4:0] OP_M_START      = 5'd14;
  localparam logic [4:0] OP_M_RDI        = 5'd15;
  localparam logic [4:0] OP_M_LDA        = 5'd16;
  localparam logic [4:0] OP_M_RDJ        = 5'd17;
  localparam logic [4:0] OP_M_JOIN       = 5'd18;
  localparam logic [4:0] OP_M_NEXTJ      = 5'd19;
  localparam logic [4:0] OP_M_INC_I      = 5'd20;
  localparam logic [4:0] OP_FIN          = 5'd21;

  typedef struct packed {
    logic [4:0] op;
    logic [2:0] status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       zero_size;
    logic       chk_big;
    logic       rel_out;
    logic       list_full;
    logic       scan_busy;
    logic       found;
    logic       fit_any;
    logic       area_ok;
    logic       alloc_ovf;
    logic       need_r;
    logic       need_b;
    logic       rem_more;
    logic       m_no_i;
    logic       m_j_end;
    logic       joined;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/gra_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gra_req_if / gra_rsp_if
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gra_req_if import gra_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [1:0]    action;
  logic [CB-1:0] rect_x;
  logic [CB-1:0] rect_y;
  logic [CB-1:0] rect_w;
  logic [CB-1:0] rect_h;
  modport source (output valid, action, rect_x, rect_y, rect_w, rect_h, input ready);
  modport sink   (input valid, action, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

interface gra_rsp_if import gra_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [2:0]    status;
  logic [CB-1:0] place_x;
  logic [CB-1:0] place_y;
  modport source (output valid, status, place_x, place_y, input ready);
  modport sink   (input valid, status, place_x, place_y, output ready);
endinterface
`default_nettype wire

// File: rtl/guillotine_rect_allocator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// guillotine_rect_allocator_top
// Free-rectangle list of a 2D atlas with best-area-fit allocation.
// ----------------------------------------------------------------------------
// Requests arrive as words on in_ch (action, rect_x/y/w/h) and each gives
// exactly one result word on out_ch (status, place_x/y). Settings are
// written through cfg_we/cfg_idx/cfg_wdata while the block is idle; the
// user must keep to this, as the block itself does not enforce it.
// One word is worked on at a time. Allocate and check scan the list at one
// entry a cycle through the single read port of the list memory. Removal
// moves each later entry down one place, and every merge pass tests one
// pair at a time; a join removes the absorbed entry and starts a new pass.
// After reset the block writes the whole-atlas entry, then raises in_ch.ready.
// A finished result waits in the output register while out_ch.ready is low;
// the next request is accepted meanwhile and its result is held back until
// the register is free.
// ----------------------------------------------------------------------------
module guillotine_rect_allocator_top import gra_pkg::*; #(
  parameter int MAX_FREE = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  gra_req_if.sink            in_ch,
  gra_rsp_if.source          out_ch,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_idx,
  input  wire logic [CB-1:0] cfg_wdata
);
  cmd_t cmd;
  sts_t sts;

  gra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gra_dp #(.MAX_FREE(MAX_FREE)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .in_action   (in_ch.action),
    .in_rect_x   (in_ch.rect_x),
    .in_rect_y   (in_ch.rect_y),
    .in_rect_w   (in_ch.rect_w),
    .in_rect_h   (in_ch.rect_h),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_status  (out_ch.status),
    .out_place_x (out_ch.place_x),
    .out_place_y (out_ch.place_y)
  );
endmodule
`default_nettype wire

// File: rtl/gra_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gra_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gra_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// File: rtl/gra_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gra_dp
// Datapath: settings, free list memory, best-fit scan, removal, merge test.
// ----------------------------------------------------------------------------
module gra_dp import gra_pkg::*; #(
  parameter int MAX_FREE = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_idx,
  input  wire logic [CB-1:0] cfg_wdata,
  input  wire logic [1:0]    in_action,
  input  wire logic [CB-1:0] in_rect_x,
  input  wire logic [CB-1:0] in_rect_y,
  input  wire logic [CB-1:0] in_rect_w,
  input  wire logic [CB-1:0] in_rect_h,
  input  wire cmd_t          cmd,
  output sts_t               sts,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [2:0]         out_status,
  output logic [CB-1:0]      out_place_x,
  output logic [CB-1:0]      out_place_y
);
  localparam int AW = $clog2(MAX_FREE);
  localparam int CW = $clog2(MAX_FREE + 1);
  localparam int TW = AREA_W + CW;
  localparam logic [CW-1:0] MAX_C  = CW'(MAX_FREE);
  localparam logic [CW:0]   MAX_C1 = (CW + 1)'(MAX_FREE + 1);

  coord_t        aw_r, ah_r;
  logic [PB-1:0] pad_r;
  logic [1:0]    act_r;
  coord_t        rx_r, ry_r, rw_r, rh_r;
  logic [CB:0]   rwp_r, rhp_r;
  coord_t        relx_r, rely_r, relw_r, relh_r;
  logic [AREA_W-1:0] p_area_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] scan_i_r;
  logic          v1_r, v2_r;
  logic [AW-1:0] idx1_r, idx2_r, bi_r;
  logic          fit2_r;
  logic [2*CB-1:0] prod2_r;
  rect_t         ent2_r, c_r, a_r;
  logic [TW-1:0] total_r;
  logic [AREA_W-1:0] best_r;
  logic          found_r, fitany_r;
  logic [CW-1:0] rem_t_r, mi_r, mj_r;
  logic          out_valid_r;
  logic [2:0]    out_status_r;
  coord_t        out_px_r, out_py_r;

  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [$bits(rect_t)-1:0] ram_wdata, ram_rdata;
  rect_t                   rd;

  gra_ram #(.WIDTH($bits(rect_t)), .DEPTH(MAX_FREE)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );
  assign rd = ram_rdata;

  logic          atlas_nz, scan_more, push_ok, fit1;
  logic [CW:0]   rem_t1, mi1;
  logic [CW:0]   need_sum;
  logic [AREA_W-1:0] waste;
  logic [CB+1:0] relx_end, rely_end;
  rect_t         whole, push_r_rect, push_b_rect, push_rel_rect, jr;
  logic          vert, hor, joined;
  logic [CB:0]   ay_end, by_end, ax_end, bx_end;

  assign atlas_nz  = (aw_r != '0) && (ah_r != '0);
  assign scan_more = scan_i_r < count_r;
  assign push_ok   = count_r < MAX_C;
  assign rem_t1    = {1'b0, rem_t_r} + (CW + 1)'(1);
  assign mi1       = {1'b0, mi_r} + (CW + 1)'(1);
  assign fit1      = ({1'b0, rd.w} >= rwp_r) && ({1'b0, rd.h} >= rhp_r);
  assign waste     = AREA_W'(prod2_r) - p_area_r;
  assign relx_end  = {2'b0, relx_r} + {1'b0, rwp_r};
  assign rely_end  = {2'b0, rely_r} + {1'b0, rhp_r};

  assign whole         = '{x: '0, y: '0, w: aw_r, h: ah_r};
  assign push_r_rect   = '{x: CB'({1'b0, c_r.x} + rwp_r), y: c_r.y,
                           w: CB'({1'b0, c_r.w} - rwp_r), h: rhp_r[CB-1:0]};
  assign push_b_rect   = '{x: c_r.x, y: CB'({1'b0, c_r.y} + rhp_r),
                           w: c_r.w, h: CB'({1'b0, c_r.h} - rhp_r)};
  assign push_rel_rect = '{x: relx_r, y: rely_r, w: relw_r, h: relh_r};

  // Join test of the held entry against the entry just read.
  assign ay_end = {1'b0, a_r.y} + {1'b0, a_r.h};
  assign by_end = {1'b0, rd.y} + {1'b0, rd.h};
  assign ax_end = {1'b0, a_r.x} + {1'b0, a_r.w};
  assign bx_end = {1'b0, rd.x} + {1'b0, rd.w};
  assign vert   = (a_r.x == rd.x) && (a_r.w == rd.w);
  assign hor    = (a_r.y == rd.y) && (a_r.h == rd.h);

  always_comb begin
    jr     = a_r;
    joined = 1'b1;
    if (vert && ay_end == {1'b0, rd.y}) begin
      jr.h = a_r.h + rd.h;
    end else if (vert && by_end == {1'b0, a_r.y}) begin
      jr.y = rd.y;
      jr.h = a_r.h + rd.h;
    end else if (hor && ax_end == {1'b0, rd.x}) begin
      jr.w = a_r.w + rd.w;
    end else if (hor && bx_end == {1'b0, a_r.x}) begin
      jr.x = rd.x;
      jr.w = a_r.w + rd.w;
    end else begin
      joined = 1'b0;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_r[AW-1:0];
    ram_wdata = push_rel_rect;
    ram_re    = 1'b0;
    ram_raddr = scan_i_r[AW-1:0];
    case (cmd.op)
      OP_INIT, OP_CLEAR: begin
        ram_we    = atlas_nz;
        ram_waddr = '0;
        ram_wdata = whole;
      end
      OP_SCAN: begin
        ram_re = scan_more;
      end
      OP_REM_RD: begin
        ram_re    = rem_t1 < {1'b0, count_r};
        ram_raddr = rem_t1[AW-1:0];
      end
      OP_REM_WR: begin
        ram_we    = 1'b1;
        ram_waddr = rem_t_r[AW-1:0];
        ram_wdata = ram_rdata;
      end
      OP_PUSH_R: begin
        ram_we    = push_ok;
        ram_wdata = push_r_rect;
      end
      OP_PUSH_B: begin
        ram_we    = push_ok;
        ram_wdata = push_b_rect;
      end
      OP_PUSH_REL: begin
        ram_we = push_ok;
      end
      OP_M_RDI: begin
        ram_re    = 1'b1;
        ram_raddr = mi_r[AW-1:0];
      end
      OP_M_RDJ: begin
        ram_re    = 1'b1;
        ram_raddr = mj_r[AW-1:0];
      end
      OP_M_JOIN: begin
        ram_we    = 1'b1;
        ram_waddr = mi_r[AW-1:0];
        ram_wdata = jr;
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_r        <= CB'(1024);
      ah_r        <= CB'(1024);
      pad_r       <= PB'(2);
      count_r     <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_AW:  aw_r  <= cfg_wdata;
          CFG_AH:  ah_r  <= cfg_wdata;
          CFG_PAD: pad_r <= cfg_wdata[PB-1:0];
          default: begin
          end
        endcase
      end
      case (cmd.op)
        OP_INIT, OP_CLEAR: count_r <= atlas_nz ? CW'(1) : '0;
        OP_REM_RD: begin
          if (!(rem_t1 < {1'b0, count_r})) begin
            count_r <= count_r - CW'(1);
          end
        end
        OP_PUSH_R, OP_PUSH_B, OP_PUSH_REL: begin
          if (push_ok) begin
            count_r <= count_r + CW'(1);
          end
        end
        default: begin
        end
      endcase
      if (cmd.op == OP_SCAN_START) begin
        v1_r <= 1'b0;
        v2_r <= 1'b0;
      end else if (cmd.op == OP_SCAN) begin
        v1_r <= scan_more;
        v2_r <= v1_r;
      end
      if (cmd.op == OP_FIN) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers of the current word.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        act_r <= in_action;
        rx_r  <= in_rect_x;
        ry_r  <= in_rect_y;
        rw_r  <= in_rect_w;
        rh_r  <= in_rect_h;
      end
      OP_PREP: begin
        rwp_r  <= {1'b0, rw_r} + (CB + 1)'({pad_r, 1'b0});
        rhp_r  <= {1'b0, rh_r} + (CB + 1)'({pad_r, 1'b0});
        relx_r <= (rx_r >= CB'(pad_r)) ? rx_r - CB'(pad_r) : '0;
        rely_r <= (ry_r >= CB'(pad_r)) ? ry_r - CB'(pad_r) : '0;
      end
      OP_AREA: begin
        p_area_r <= rwp_r * rhp_r;
        relw_r   <= (relx_end > {2'b0, aw_r}) ? aw_r - relx_r : rwp_r[CB-1:0];
        relh_r   <= (rely_end > {2'b0, ah_r}) ? ah_r - rely_r : rhp_r[CB-1:0];
      end
      OP_SCAN_START: begin
        scan_i_r <= '0;
        found_r  <= 1'b0;
        fitany_r <= 1'b0;
        total_r  <= '0;
      end
      OP_SCAN: begin
        if (scan_more) begin
          idx1_r   <= scan_i_r[AW-1:0];
          scan_i_r <= scan_i_r + CW'(1);
        end
        if (v1_r) begin
          fit2_r  <= fit1;
          prod2_r <= rd.w * rd.h;
          ent2_r  <= rd;
          idx2_r  <= idx1_r;
        end
        if (v2_r) begin
          total_r <= total_r + TW'(prod2_r);
          if (fit2_r) begin
            fitany_r <= 1'b1;
            // Strict compare keeps the lowest index on equal waste.
            if (!found_r || waste < best_r) begin
              found_r <= 1'b1;
              best_r  <= waste;
              bi_r    <= idx2_r;
              c_r     <= ent2_r;
            end
          end
        end
      end
      OP_REM_START_BI: rem_t_r <= CW'(bi_r);
      OP_REM_WR:       rem_t_r <= rem_t_r + CW'(1);
      OP_M_START:      mi_r <= '0;
      OP_M_RDI:        mj_r <= mi1[CW-1:0];
      OP_M_LDA:        a_r  <= rd;
      OP_M_NEXTJ:      mj_r <= mj_r + CW'(1);
      OP_M_INC_I:      mi_r <= mi1[CW-1:0];
      OP_M_JOIN:       rem_t_r <= mj_r;
      OP_FIN: begin
        out_status_r <= cmd.status;
        if (cmd.status == ST_OK && act_r == ACT_ALLOC) begin
          out_px_r <= CB'({1'b0, c_r.x} + (CB + 1)'(pad_r));
          out_py_r <= CB'({1'b0, c_r.y} + (CB + 1)'(pad_r));
        end else begin
          out_px_r <= '0;
          out_py_r <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign need_sum = {1'b0, count_r} + (CW + 1)'({1'b0, c_r.w} > rwp_r)
                  + (CW + 1)'({1'b0, c_r.h} > rhp_r);

  always_comb begin
    sts.act       = act_r;
    sts.zero_size = (rw_r == '0) || (rh_r == '0);
    sts.chk_big   = (rwp_r > {1'b0, aw_r}) || (rhp_r > {1'b0, ah_r});
    sts.rel_out   = (relx_r >= aw_r) || (rely_r >= ah_r);
    sts.list_full = count_r >= MAX_C;
    sts.scan_busy = scan_more || v1_r || v2_r;
    sts.found     = found_r;
    sts.fit_any   = fitany_r;
    sts.area_ok   = total_r >= TW'(p_area_r);
    sts.need_r    = {1'b0, c_r.w} > rwp_r;
    sts.need_b    = {1'b0, c_r.h} > rhp_r;
    sts.alloc_ovf = need_sum > MAX_C1;
    sts.rem_more  = rem_t1 < {1'b0, count_r};
    sts.m_no_i    = mi1 >= {1'b0, count_r};
    sts.m_j_end   = mj_r >= count_r;
    sts.joined    = joined;
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_place_x = out_px_r;
  assign out_place_y = out_py_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_C) else $error("free list count above capacity");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_PUSH_R || cmd.op == OP_PUSH_B || cmd.op == OP_PUSH_REL) |-> push_ok)
    else $error("push issued on a full free list");

  a_scan_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> $past(v1_r)) else $error("scan stage two valid without stage one");

  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FIN && sts.out_free) |=> out_valid_r)
    else $error("finished word not presented");

endmodule
`default_nettype wire

// File: rtl/gra_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gra_ctrl
// Sequencer: steps the datapath through scan, removal, push and merge.
// ----------------------------------------------------------------------------
module gra_ctrl import gra_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  localparam logic [4:0] S_INIT     = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_PREP     = 5'd2;
  localparam logic [4:0] S_AREA     = 5'd3;
  localparam logic [4:0] S_DECIDE   = 5'd4;
  localparam logic [4:0] S_SCAN0    = 5'd5;
  localparam logic [4:0] S_SCAN     = 5'd6;
  localparam logic [4:0] S_SCAN_END = 5'd7;
  localparam logic [4:0] S_REM_RD   = 5'd8;
  localparam logic [4:0] S_REM_WR   = 5'd9;
  localparam logic [4:0] S_PUSH_R   = 5'd10;
  localparam logic [4:0] S_PUSH_B   = 5'd11;
  localparam logic [4:0] S_MSTART   = 5'd12;
  localparam logic [4:0] S_MRDI     = 5'd13;
  localparam logic [4:0] S_MLDA     = 5'd14;
  localparam logic [4:0] S_MRDJ     = 5'd15;
  localparam logic [4:0] S_MTST     = 5'd16;
  localparam logic [4:0] S_FIN      = 5'd17;

  logic [4:0] state_r, state_nxt;
  logic [2:0] stat_r, stat_nxt;
  logic       ret_merge_r, ret_merge_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      stat_r      <= ST_OK;
      ret_merge_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stat_r      <= stat_nxt;
      ret_merge_r <= ret_merge_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    stat_nxt      = stat_r;
    ret_merge_nxt = ret_merge_r;
    cmd.op        = OP_NONE;
    cmd.status    = stat_r;
    in_ready      = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.op    = OP_INIT;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.op    = OP_PREP;
        state_nxt = S_AREA;
      end
      S_AREA: begin
        cmd.op    = OP_AREA;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_FIN;
        if (sts.act == ACT_CLEAR) begin
          cmd.op   = OP_CLEAR;
          stat_nxt = ST_OK;
        end else if (sts.zero_size) begin
          stat_nxt = ST_INVALID;
        end else if (sts.act == ACT_ALLOC) begin
          state_nxt = S_SCAN0;
        end else if (sts.act == ACT_CHECK) begin
          if (sts.chk_big) begin
            stat_nxt = ST_NOSPACE;
          end else begin
            state_nxt = S_SCAN0;
          end
        end else if (sts.rel_out) begin
          stat_nxt = ST_INVALID;
        end else if (sts.list_full) begin
          stat_nxt = ST_OVF;
        end else begin
          cmd.op    = OP_PUSH_REL;
          state_nxt = S_MSTART;
        end
      end
      S_SCAN0: begin
        cmd.op    = OP_SCAN_START;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (!sts.scan_busy) begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_nxt = S_FIN;
        if (sts.act == ACT_CHECK) begin
          if (sts.fit_any) begin
            stat_nxt = ST_OK;
          end else if (sts.area_ok) begin
            stat_nxt = ST_FRAG;
          end else begin
            stat_nxt = ST_NOSPACE;
          end
        end else if (!sts.found) begin
          stat_nxt = ST_NOFIT;
        end else if (sts.alloc_ovf) begin
          stat_nxt = ST_OVF;
        end else begin
          cmd.op        = OP_REM_START_BI;
          ret_merge_nxt = 1'b0;
          state_nxt     = S_REM_RD;
        end
      end
      S_REM_RD: begin
        cmd.op = OP_REM_RD;
        if (sts.rem_more) begin
          state_nxt = S_REM_WR;
        end else if (ret_merge_r) begin
          state_nxt = S_MSTART;
        end else begin
          state_nxt = S_PUSH_R;
        end
      end
      S_REM_WR: begin
        cmd.op    = OP_REM_WR;
        state_nxt = S_REM_RD;
      end
      S_PUSH_R: begin
        if (sts.need_r) begin
          cmd.op = OP_PUSH_R;
        end
        state_nxt = S_PUSH_B;
      end
      S_PUSH_B: begin
        if (sts.need_b) begin
          cmd.op = OP_PUSH_B;
        end
        state_nxt = S_MSTART;
      end
      S_MSTART: begin
        cmd.op    = OP_M_START;
        state_nxt = S_MRDI;
      end
      S_MRDI: begin
        // A pass that reaches the last entry without a join ends merging.
        if (sts.m_no_i) begin
          stat_nxt  = ST_OK;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = OP_M_RDI;
          state_nxt = S_MLDA;
        end
      end
      S_MLDA: begin
        cmd.op    = OP_M_LDA;
        state_nxt = S_MRDJ;
      end
      S_MRDJ: begin
        if (sts.m_j_end) begin
          cmd.op    = OP_M_INC_I;
          state_nxt = S_MRDI;
        end else begin
          cmd.op    = OP_M_RDJ;
          state_nxt = S_MTST;
        end
      end
      S_MTST: begin
        if (sts.joined) begin
          cmd.op        = OP_M_JOIN;
          ret_merge_nxt = 1'b1;
          state_nxt     = S_REM_RD;
        end else begin
          cmd.op    = OP_M_NEXTJ;
          state_nxt = S_MRDJ;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.op    = OP_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end
endmodule
`default_nettype wire
